### rtl/cvam_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// cvam_pkg
// Shared types and class codes for the cell voltage alarm monitor.
// ---------------------------------------------------------------------------
package cvam_pkg;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 60;
   localparam int CELL_W     = 16;
   localparam int TOTAL_W    = 20;
   localparam int CLASS_W    = 4;
   localparam int CELL_CLS_W = 3;
   localparam int MASK_W     = 15;

   // register indexes on the csr port
   localparam logic [CSR_IDX_W-1:0] REG_CELL_LOW   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_CELL_HIGH  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_TOTAL_LOW  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_TOTAL_HIGH = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_SPREAD     = 3'd4;

   // class codes
   localparam logic [CLASS_W-1:0] CLS_NORMAL     = 4'd0;
   localparam logic [CLASS_W-1:0] CLS_CELL_BASE  = 4'd1;
   localparam logic [CLASS_W-1:0] CLS_TOTAL_BASE = 4'd7;
   localparam logic [CLASS_W-1:0] CLS_SPREAD_ONE = 4'd13;
   localparam logic [CLASS_W-1:0] CLS_SPREAD_TWO = 4'd14;

   // offsets from a ladder's base code
   localparam logic [CLASS_W-1:0] OFS_LOW     = 4'd0;
   localparam logic [CLASS_W-1:0] OFS_LOW_L1  = 4'd1;
   localparam logic [CLASS_W-1:0] OFS_LOW_L2  = 4'd2;
   localparam logic [CLASS_W-1:0] OFS_HIGH    = 4'd3;
   localparam logic [CLASS_W-1:0] OFS_HIGH_L1 = 4'd4;
   localparam logic [CLASS_W-1:0] OFS_HIGH_L2 = 4'd5;

   // six thresholds of one ladder, cell thresholds zero-extended
   typedef struct packed {
      logic [TOTAL_W-1:0] l1;
      logic [TOTAL_W-1:0] l2;
      logic [TOTAL_W-1:0] lo;
      logic [TOTAL_W-1:0] h1;
      logic [TOTAL_W-1:0] h2;
      logic [TOTAL_W-1:0] hi;
   } thr_type;

endpackage
`default_nettype wire

### rtl/cvam_classify.sv
`default_nettype none
// ---------------------------------------------------------------------------
// cvam_classify
// Six-threshold ladder: low side first, a true high compare overrides it.
// ---------------------------------------------------------------------------
module cvam_classify (
   input  wire logic [cvam_pkg::TOTAL_W-1:0] value,
   input  wire logic [cvam_pkg::CLASS_W-1:0] base,
   input  wire cvam_pkg::thr_type            thr,
   output logic      [cvam_pkg::CLASS_W-1:0] cls
);
   import cvam_pkg::*;

   always_comb begin
      cls = CLS_NORMAL;
      if (value < thr.l1) begin
         cls = base + OFS_LOW_L1;
      end else if (value < thr.l2) begin
         cls = base + OFS_LOW_L2;
      end else if (value < thr.lo) begin
         cls = base + OFS_LOW;
      end
      if (value > thr.h1) begin
         cls = base + OFS_HIGH_L1;
      end else if (value > thr.h2) begin
         cls = base + OFS_HIGH_L2;
      end else if (value > thr.hi) begin
         cls = base + OFS_HIGH;
      end
   end

endmodule
`default_nettype wire

### rtl/cell_voltage_alarm_monitor_top.sv
`default_nettype none
// ---------------------------------------------------------------------------
// cell_voltage_alarm_monitor_top
// Takes one cell per cycle unless rsp backpressure stalls a scan's last cell;
// the result goes via the input, scan-end and result registers. Throughput is
// limited only by rsp backpressure on scan-end items. Synchronous reset zeroes
// low thresholds, sets others to ones, clears stored classes and scan state.
// ---------------------------------------------------------------------------
module cell_voltage_alarm_monitor_top #(
   parameter int CELLS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [15:0] req_cell_voltage,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [15:0]      rsp_max_cell,
   output logic [15:0]      rsp_min_cell,
   output logic [19:0]      rsp_pack_total,
   output logic [3:0]       rsp_total_class,
   output logic [3:0]       rsp_spread_class,
   output logic [14:0]      rsp_change_mask,
   output logic             rsp_any_change,
   input  wire logic        csr_we,
   input  wire logic [cvam_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [cvam_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import cvam_pkg::*;

   localparam int POS_W = (CELLS > 1) ? $clog2(CELLS) : 1;

   // configuration
   logic [47:0] cell_low_ff, cell_high_ff;
   logic [59:0] total_low_ff, total_high_ff;
   logic [31:0] spread_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_low_ff   <= '0;
         cell_high_ff  <= '1;
         total_low_ff  <= '0;
         total_high_ff <= '1;
         spread_ff     <= '1;
      end else if (csr_we) begin
         case (csr_index)
            REG_CELL_LOW:   cell_low_ff   <= csr_wdata[47:0];
            REG_CELL_HIGH:  cell_high_ff  <= csr_wdata[47:0];
            REG_TOTAL_LOW:  total_low_ff  <= csr_wdata;
            REG_TOTAL_HIGH: total_high_ff <= csr_wdata;
            REG_SPREAD:     spread_ff     <= csr_wdata[31:0];
            default: ;
         endcase
      end
   end

   // flow control
   logic v0_valid_ff, fin_valid_ff, rsp_valid_ff;
   logic out_free, fin_free, s0_fire, last_cell;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign fin_free  = !fin_valid_ff || out_free;
   assign s0_fire   = v0_valid_ff && (!last_cell || fin_free);
   assign req_ready = !v0_valid_ff || s0_fire;

   // input register
   logic [CELL_W-1:0] v0_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_valid_ff <= 1'b0;
      end else if (req_ready) begin
         v0_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         v0_ff <= req_cell_voltage;
      end
   end

   // cell stage
   logic [POS_W-1:0]      pos_ff;
   logic [CELL_W-1:0]     run_max_ff, run_min_ff;
   logic [TOTAL_W-1:0]    run_total_ff;
   logic [MASK_W-1:0]     pend_mask_ff;
   logic [CELL_CLS_W-1:0] cls_store_ff [CELLS];

   logic [CELL_W-1:0]     max_in, min_in;
   logic [TOTAL_W-1:0]    total_in;
   logic [MASK_W-1:0]     mask_in;
   logic [CLASS_W-1:0]    cell_cls;
   logic [CELL_CLS_W-1:0] cell_cls_n;
   logic                  cell_changed;
   thr_type               cell_thr;

   assign last_cell = (pos_ff == POS_W'(CELLS - 1));

   always_comb begin
      cell_thr.l1 = {4'b0, cell_low_ff[15:0]};
      cell_thr.l2 = {4'b0, cell_low_ff[31:16]};
      cell_thr.lo = {4'b0, cell_low_ff[47:32]};
      cell_thr.h1 = {4'b0, cell_high_ff[15:0]};
      cell_thr.h2 = {4'b0, cell_high_ff[31:16]};
      cell_thr.hi = {4'b0, cell_high_ff[47:32]};
   end

   cvam_classify u_cell_cls (
      .value (TOTAL_W'(v0_ff)),
      .base  (CLS_CELL_BASE),
      .thr   (cell_thr),
      .cls   (cell_cls)
   );

   assign cell_cls_n   = cell_cls[CELL_CLS_W-1:0];
   assign cell_changed = (cls_store_ff[pos_ff] != cell_cls_n);
   assign max_in       = (v0_ff > run_max_ff) ? v0_ff : run_max_ff;
   assign min_in       = (v0_ff < run_min_ff) ? v0_ff : run_min_ff;
   assign total_in     = run_total_ff + TOTAL_W'(v0_ff);
   assign mask_in      = pend_mask_ff
                       | (cell_changed ? (MASK_W'(1) << cell_cls_n) : '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         run_max_ff   <= '0;
         run_min_ff   <= '1;
         run_total_ff <= '0;
         pend_mask_ff <= '0;
         for (int i = 0; i < CELLS; i++) begin
            cls_store_ff[i] <= '0;
         end
      end else if (s0_fire) begin
         cls_store_ff[pos_ff] <= cell_cls_n;
         if (last_cell) begin
            pos_ff       <= '0;
            run_max_ff   <= '0;
            run_min_ff   <= '1;
            run_total_ff <= '0;
            pend_mask_ff <= '0;
         end else begin
            pos_ff       <= pos_ff + POS_W'(1);
            run_max_ff   <= max_in;
            run_min_ff   <= min_in;
            run_total_ff <= total_in;
            pend_mask_ff <= mask_in;
         end
      end
   end

   // scan-end stage: snapshot of the finished scan
   logic [CELL_W-1:0]  fin_max_ff, fin_min_ff;
   logic [TOTAL_W-1:0] fin_total_ff;
   logic [MASK_W-1:0]  fin_mask_ff;
   logic               fin_load, fin_move;

   assign fin_load = s0_fire && last_cell;
   assign fin_move = fin_valid_ff && out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         fin_valid_ff <= 1'b0;
      end else if (fin_free) begin
         fin_valid_ff <= fin_load;
      end
   end

   always_ff @(posedge clock) begin
      if (fin_load) begin
         fin_max_ff   <= max_in;
         fin_min_ff   <= min_in;
         fin_total_ff <= total_in;
         fin_mask_ff  <= mask_in;
      end
   end

   logic [CLASS_W-1:0] total_cls_ff, spread_cls_ff;
   logic [CLASS_W-1:0] total_cls, spread_cls;
   logic [CELL_W-1:0]  spread;
   logic [MASK_W-1:0]  final_mask;
   thr_type            total_thr;

   always_comb begin
      total_thr.l1 = total_low_ff[19:0];
      total_thr.l2 = total_low_ff[39:20];
      total_thr.lo = total_low_ff[59:40];
      total_thr.h1 = total_high_ff[19:0];
      total_thr.h2 = total_high_ff[39:20];
      total_thr.hi = total_high_ff[59:40];
   end

   cvam_classify u_total_cls (
      .value (fin_total_ff),
      .base  (CLS_TOTAL_BASE),
      .thr   (total_thr),
      .cls   (total_cls)
   );

   assign spread = fin_max_ff - fin_min_ff;

   always_comb begin
      if (spread > spread_ff[15:0]) begin
         spread_cls = CLS_SPREAD_ONE;
      end else if (spread > spread_ff[31:16]) begin
         spread_cls = CLS_SPREAD_TWO;
      end else begin
         spread_cls = CLS_NORMAL;
      end
   end

   always_comb begin
      final_mask = fin_mask_ff;
      if (total_cls != total_cls_ff) begin
         final_mask = final_mask | (MASK_W'(1) << total_cls);
      end
      if (spread_cls != spread_cls_ff) begin
         final_mask = final_mask | (MASK_W'(1) << spread_cls);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_cls_ff  <= CLS_NORMAL;
         spread_cls_ff <= CLS_NORMAL;
      end else if (fin_move) begin
         total_cls_ff  <= total_cls;
         spread_cls_ff <= spread_cls;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= fin_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (fin_move) begin
         rsp_max_cell     <= fin_max_ff;
         rsp_min_cell     <= fin_min_ff;
         rsp_pack_total   <= fin_total_ff;
         rsp_total_class  <= total_cls;
         rsp_spread_class <= spread_cls;
         rsp_change_mask  <= final_mask;
         rsp_any_change   <= (final_mask != '0);
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule
`default_nettype wire
